### rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Types and codes shared by the pending command timeout tracker.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int CountW = 5;

    localparam logic [2:0] CMD_BEGIN    = 3'd0;
    localparam logic [2:0] CMD_COMPLETE = 3'd1;
    localparam logic [2:0] CMD_QUERY    = 3'd2;
    localparam logic [2:0] CMD_EXPIRE   = 3'd3;
    localparam logic [2:0] CMD_CLEAR    = 3'd4;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_NONE      = 2'd3;

    localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
    localparam logic [31:0] FIRST_ID      = 32'd1;

    typedef struct packed {
        logic [2:0]  command;
        logic [47:0] node_address;
        logic [7:0]  relay_pin;
        logic        desired_on;
        logic [31:0] now_ms;
        logic [31:0] command_id;
    } item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       result_id;
        logic [47:0]       result_node;
        logic [7:0]        result_pin;
        logic              result_desired;
        logic [31:0]       result_sent_ms;
        logic [CountW-1:0] pending_count;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [31:0] id;
        logic [47:0] node;
        logic [7:0]  pin;
        logic        wanted;
        logic [31:0] sent_ms;
    } entry_t;

endpackage

### rtl/ptt_mem.sv
// ----------------------------------------------------------------------------
// ptt_mem
// Entry table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptt_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  ptt_pkg::entry_t     wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output ptt_pkg::entry_t     rd_data
);

    ptt_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/ptt_cmp.sv
// ----------------------------------------------------------------------------
// ptt_cmp
// Shared compare unit: id match for lookups, wrapped age test for scans.
// ----------------------------------------------------------------------------
module ptt_cmp (
    input  logic            expire_mode,
    input  ptt_pkg::entry_t entry,
    input  logic [31:0]     command_id,
    input  logic [31:0]     now_ms,
    input  logic [31:0]     timeout_ms,
    output logic            hit
);

    logic [31:0] elapsed;

    // modulo 2^32 age, so a wrapped clock still measures correctly
    assign elapsed = now_ms - entry.sent_ms;
    assign hit     = expire_mode ? (elapsed > timeout_ms) : (entry.id == command_id);

endmodule

### rtl/pending_command_timeout_tracker.sv
// ----------------------------------------------------------------------------
// pending_command_timeout_tracker
// Insertion-ordered table of outstanding relay commands with timeout scan.
// ----------------------------------------------------------------------------
//  channel  | ports                        | handshake
//  ---------+------------------------------+-------------------------------
//  command  | start, busy, item            | beat when start && !busy
//  result   | result_valid, result         | one-cycle strobe, no backpressure
//  config   | cfg_we, cfg_wdata            | timeout_ms written when cfg_we
//
//  Begin, clear and unknown codes finish in the accept cycle; busy never rises.
//  Complete, query and scan on a non-empty table walk it through the single
//  read port: a fetch and a check state per entry visited, a shift-fetch and
//  a shift-write state per entry moved on compaction, and a flush at scan end.
//  Reset empties the table and sets the next id to 1; entry storage is not
//  cleared. Results leave from a register and cannot be stalled.
// ----------------------------------------------------------------------------
module pending_command_timeout_tracker #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ptt_pkg::item_t     item,
    output logic               result_valid,
    output ptt_pkg::result_t   result,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_FLUSH,
        S_SHIFT_FETCH,
        S_SHIFT_WRITE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       next_id_reg, next_id_next;
    logic [31:0]       timeout_reg;
    ptt_pkg::item_t    item_reg, item_next;
    ptt_pkg::entry_t   held_reg, held_next;
    logic              held_valid_reg, held_valid_next;
    ptt_pkg::result_t  result_reg, result_next;
    logic              result_valid_reg, result_valid_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    ptt_pkg::entry_t   wr_data;
    ptt_pkg::entry_t   rd_data;
    logic              hit;
    logic [CNT_W-1:0]  ptr_inc;
    logic [CNT_W-1:0]  ptr_dec;
    logic              at_end;
    logic              expire_mode;

    assign ptr_inc     = ptr_reg + CNT_W'(1);
    assign ptr_dec     = ptr_reg - CNT_W'(1);
    assign at_end      = (ptr_inc == count_reg);
    assign expire_mode = (item_reg.command == ptt_pkg::CMD_EXPIRE);

    ptt_mem #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ptr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    ptt_cmp u_cmp (
        .expire_mode (expire_mode),
        .entry       (rd_data),
        .command_id  (item_reg.command_id),
        .now_ms      (item_reg.now_ms),
        .timeout_ms  (timeout_reg),
        .hit         (hit)
    );

    always_comb
    begin
        state_next        = state_reg;
        ptr_next          = ptr_reg;
        count_next        = count_reg;
        next_id_next      = next_id_reg;
        item_next         = item_reg;
        held_next         = held_reg;
        held_valid_next   = held_valid_reg;
        result_next       = '0;
        result_valid_next = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = ptr_dec[IDX_W-1:0];
        wr_data           = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next         = item;
                    ptr_next          = '0;
                    held_valid_next   = 1'b0;
                    result_valid_next = 1'b1;
                    result_next.last  = 1'b1;
                    case (item.command)
                        ptt_pkg::CMD_BEGIN:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                result_next.status = ptt_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en              = 1'b1;
                                wr_addr            = count_reg[IDX_W-1:0];
                                wr_data.id         = next_id_reg;
                                wr_data.node       = item.node_address;
                                wr_data.pin        = item.relay_pin;
                                wr_data.wanted     = item.desired_on;
                                wr_data.sent_ms    = item.now_ms;
                                count_next         = count_reg + CNT_W'(1);
                                next_id_next       = next_id_reg + 32'd1;
                                result_next.status = ptt_pkg::STATUS_OK;
                                result_next.result_id = next_id_reg;
                            end
                        end
                        ptt_pkg::CMD_COMPLETE, ptt_pkg::CMD_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next.status = ptt_pkg::STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                result_valid_next = 1'b0;
                                state_next        = S_FETCH;
                            end
                        end
                        ptt_pkg::CMD_EXPIRE:
                        begin
                            if (count_reg == '0)
                            begin
                                result_next.status = ptt_pkg::STATUS_NONE;
                            end
                            else
                            begin
                                result_valid_next = 1'b0;
                                state_next        = S_FETCH;
                            end
                        end
                        ptt_pkg::CMD_CLEAR:
                        begin
                            count_next         = '0;
                            result_next.status = ptt_pkg::STATUS_OK;
                        end
                        default:
                        begin
                            result_next.status = ptt_pkg::STATUS_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (expire_mode)
                begin
                    if (hit)
                    begin
                        // the previous hit is now known not to be the last one
                        if (held_valid_reg)
                        begin
                            result_valid_next          = 1'b1;
                            result_next.status         = ptt_pkg::STATUS_OK;
                            result_next.result_id      = held_reg.id;
                            result_next.result_node    = held_reg.node;
                            result_next.result_pin     = held_reg.pin;
                            result_next.result_desired = held_reg.wanted;
                            result_next.result_sent_ms = held_reg.sent_ms;
                        end
                        held_next       = rd_data;
                        held_valid_next = 1'b1;
                    end
                    if (at_end)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        state_next = S_FETCH;
                    end
                end
                else if (hit)
                begin
                    if (item_reg.command == ptt_pkg::CMD_QUERY || at_end)
                    begin
                        if (item_reg.command != ptt_pkg::CMD_QUERY)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                        result_valid_next  = 1'b1;
                        result_next.status = ptt_pkg::STATUS_OK;
                        result_next.last   = 1'b1;
                        state_next         = S_IDLE;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        state_next = S_SHIFT_FETCH;
                    end
                end
                else if (at_end)
                begin
                    result_valid_next  = 1'b1;
                    result_next.status = ptt_pkg::STATUS_NOT_FOUND;
                    result_next.last   = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_FETCH;
                end
            end
            S_FLUSH:
            begin
                result_valid_next = 1'b1;
                result_next.last  = 1'b1;
                if (held_valid_reg)
                begin
                    result_next.status         = ptt_pkg::STATUS_OK;
                    result_next.result_id      = held_reg.id;
                    result_next.result_node    = held_reg.node;
                    result_next.result_pin     = held_reg.pin;
                    result_next.result_desired = held_reg.wanted;
                    result_next.result_sent_ms = held_reg.sent_ms;
                end
                else
                begin
                    result_next.status = ptt_pkg::STATUS_NONE;
                end
                state_next = S_IDLE;
            end
            S_SHIFT_FETCH:
            begin
                state_next = S_SHIFT_WRITE;
            end
            S_SHIFT_WRITE:
            begin
                // move entry ptr down one slot to close the gap
                wr_en = 1'b1;
                if (at_end)
                begin
                    count_next         = count_reg - CNT_W'(1);
                    result_valid_next  = 1'b1;
                    result_next.status = ptt_pkg::STATUS_OK;
                    result_next.last   = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_SHIFT_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        result_next.pending_count = ptt_pkg::CountW'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ptr_reg          <= '0;
            count_reg        <= '0;
            next_id_reg      <= ptt_pkg::FIRST_ID;
            timeout_reg      <= ptt_pkg::TIMEOUT_RESET;
            item_reg         <= '0;
            held_reg         <= '0;
            held_valid_reg   <= 1'b0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ptr_reg          <= ptr_next;
            count_reg        <= count_next;
            next_id_reg      <= next_id_next;
            item_reg         <= item_next;
            held_reg         <= held_next;
            held_valid_reg   <= held_valid_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above table depth");

    a_mid_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.last |-> busy)
        else $error("non-final beat outside a scan");

    a_last_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.last |-> !busy)
        else $error("final beat while still busy");

    a_shift_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT_WRITE |-> ptr_reg != '0 && ptr_reg < count_reg)
        else $error("compaction pointer out of range");

    a_begin_grows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == ptt_pkg::CMD_BEGIN && count_reg != DEPTH_C
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("begin did not append an entry");

endmodule

### test/tb_pending_command_timeout_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pending_command_timeout_tracker
// Self-checking bench for the pending command timeout tracker. A short table
// of directed beats is followed by random command traffic over several
// timeout settings. Every accepted beat is run through a local model of the
// table; results are checked field by field against it or a typed row's want.
// ----------------------------------------------------------------------------
module tb_pending_command_timeout_tracker;

    localparam int DEPTH = 16;
    localparam int SETTLE = 2 * DEPTH + 8;
    localparam int PHASE_ITEMS = 74;
    localparam int PHASES = 6;

    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    typedef struct packed {
        ptt_pkg::item_t   beat;
        int               reps;
        bit               rnd;
        bit               typed;
        ptt_pkg::result_t want;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    ptt_pkg::item_t   cmd_in;
    logic             result_valid;
    ptt_pkg::result_t reply;
    logic             cfg_we;
    logic [31:0]      cfg_wdata;

    // local copy of the table
    ptt_pkg::entry_t  tbl [DEPTH];
    int               tbl_cnt;
    logic [31:0]      id_next;
    logic [31:0]      timeout_val;

    ptt_pkg::result_t due_results [$];
    row_t             dir_rows [$];
    int               mismatch_count;
    logic [31:0]      wall_ms;

    pending_command_timeout_tracker #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(cmd_in),
        .result_valid(result_valid),
        .result(reply),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    function automatic logic [31:0] pick_id();
        if (tbl_cnt > 0 && $urandom_range(0, 4) != 0)
            return tbl[$urandom_range(0, tbl_cnt - 1)].id;
        return $urandom;
    endfunction

    // Applies one accepted beat to the local table and queues its results.
    function automatic void track_command(ptt_pkg::item_t beat);
        ptt_pkg::result_t r;
        int               i;
        int               hit;
        int               hits;
        int               seen;
        logic [31:0]      elapsed;
        r = '0;
        r.last = 1'b1;
        hit = -1;
        for (i = 0; i < tbl_cnt; i++)
        begin
            if (hit < 0 && tbl[i].id == beat.command_id)
                hit = i;
        end
        case (beat.command)
            ptt_pkg::CMD_BEGIN:
            begin
                if (tbl_cnt >= DEPTH)
                begin
                    r.status = ptt_pkg::STATUS_FULL;
                end
                else
                begin
                    tbl[tbl_cnt] = '{id: id_next, node: beat.node_address,
                                     pin: beat.relay_pin, wanted: beat.desired_on,
                                     sent_ms: beat.now_ms};
                    tbl_cnt++;
                    r.status = ptt_pkg::STATUS_OK;
                    r.result_id = id_next;
                    id_next = id_next + 32'd1;
                end
            end
            ptt_pkg::CMD_COMPLETE:
            begin
                if (hit < 0)
                begin
                    r.status = ptt_pkg::STATUS_NOT_FOUND;
                end
                else
                begin
                    for (i = hit; i + 1 < tbl_cnt; i++)
                        tbl[i] = tbl[i + 1];
                    tbl_cnt--;
                    r.status = ptt_pkg::STATUS_OK;
                end
            end
            ptt_pkg::CMD_QUERY:
                r.status = (hit < 0) ? ptt_pkg::STATUS_NOT_FOUND : ptt_pkg::STATUS_OK;
            ptt_pkg::CMD_EXPIRE:
            begin
                hits = 0;
                for (i = 0; i < tbl_cnt; i++)
                begin
                    elapsed = beat.now_ms - tbl[i].sent_ms;
                    if (elapsed > timeout_val)
                        hits++;
                end
                if (hits == 0)
                begin
                    r.status = ptt_pkg::STATUS_NONE;
                end
                else
                begin
                    seen = 0;
                    for (i = 0; i < tbl_cnt; i++)
                    begin
                        elapsed = beat.now_ms - tbl[i].sent_ms;
                        if (elapsed > timeout_val)
                        begin
                            seen++;
                            r = '0;
                            r.status = ptt_pkg::STATUS_OK;
                            r.result_id = tbl[i].id;
                            r.result_node = tbl[i].node;
                            r.result_pin = tbl[i].pin;
                            r.result_desired = tbl[i].wanted;
                            r.result_sent_ms = tbl[i].sent_ms;
                            r.pending_count = tbl_cnt[ptt_pkg::CountW-1:0];
                            r.last = (seen == hits);
                            due_results.insert(due_results.size(), r);
                        end
                    end
                    return;
                end
            end
            ptt_pkg::CMD_CLEAR:
            begin
                tbl_cnt = 0;
                r.status = ptt_pkg::STATUS_OK;
            end
            default:
                r.status = ptt_pkg::STATUS_NOT_FOUND;
        endcase
        r.pending_count = tbl_cnt[ptt_pkg::CountW-1:0];
        due_results.insert(due_results.size(), r);
    endfunction

    function automatic void add_row(logic [2:0] cmd, logic [47:0] node, logic [7:0] pin,
                                    logic on, logic [31:0] now, logic [31:0] cid,
                                    int reps, bit rnd, bit typed, logic [1:0] st,
                                    logic [31:0] rid, logic [ptt_pkg::CountW-1:0] cnt);
        row_t row;
        row.beat = '{command: cmd, node_address: node, relay_pin: pin,
                     desired_on: on, now_ms: now, command_id: cid};
        row.reps = reps;
        row.rnd = rnd;
        row.typed = typed;
        row.want = '0;
        row.want.status = st;
        row.want.result_id = rid;
        row.want.pending_count = cnt;
        row.want.last = 1'b1;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : watch
        ptt_pkg::result_t want;
        if (rst_n && result_valid !== 1'b0)
        begin
            if (due_results.size() == 0)
            begin
                flag_mismatch("result strobe with nothing expected");
            end
            else
            begin
                want = due_results.pop_front();
                check_field("status", reply.status, want.status);
                check_field("result_id", reply.result_id, want.result_id);
                check_field("result_node", reply.result_node, want.result_node);
                check_field("result_pin", reply.result_pin, want.result_pin);
                check_field("result_desired", reply.result_desired, want.result_desired);
                check_field("result_sent_ms", reply.result_sent_ms, want.result_sent_ms);
                check_field("pending_count", reply.pending_count, want.pending_count);
                check_field("last", reply.last, want.last);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic issue(ptt_pkg::item_t beat, bit typed, ptt_pkg::result_t want);
        start <= 1'b1;
        cmd_in <= beat;
        do @(posedge clk); while (busy);
        track_command(beat);
        if (typed)
        begin
            void'(due_results.pop_back());
            due_results.insert(due_results.size(), want);
        end
        @(negedge clk);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Waits for all results, then waits out the SETTLE margin.
    task automatic drain();
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_timeout(logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        timeout_val = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stim
        logic [31:0]    tmo_list [PHASES];
        ptt_pkg::item_t beat;
        row_t           row;
        int             phase;
        int             n;
        int             k;
        int             roll;
        bit             idle_on;

        rst_n = 1'b0;
        start = 1'b0;
        cmd_in = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        tbl_cnt = 0;
        id_next = ptt_pkg::FIRST_ID;
        timeout_val = ptt_pkg::TIMEOUT_RESET;
        mismatch_count = 0;
        idle_on = 1'b0;

        // id wrap and duplicate ids need 2^32 begins, out of reach here
        add_row(ptt_pkg::CMD_QUERY, '0, '0, 1'b0, '0, 32'd1, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_NOT_FOUND, '0, 5'd0);
        add_row(ptt_pkg::CMD_EXPIRE, '0, '0, 1'b0, '0, '0, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_NONE, '0, 5'd0);
        add_row(ptt_pkg::CMD_COMPLETE, '0, '0, 1'b0, '0, 32'hFFFF_FFFF, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_NOT_FOUND, '0, 5'd0);
        add_row(ptt_pkg::CMD_BEGIN, '0, '0, 1'b0, '0, '0, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_OK, 32'd1, 5'd1);
        add_row(ptt_pkg::CMD_BEGIN, 48'hFFFF_FFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 1, 1'b0, 1'b1, ptt_pkg::STATUS_OK, 32'd2, 5'd2);
        add_row(ptt_pkg::CMD_BEGIN, '0, '0, 1'b0, '0, '0, 14, 1'b1, 1'b0,
                ptt_pkg::STATUS_OK, '0, '0);
        add_row(ptt_pkg::CMD_BEGIN, 48'h1234_5678_9ABC, 8'h5A, 1'b1, 32'd7, '0, 1, 1'b0,
                1'b1, ptt_pkg::STATUS_FULL, '0, 5'd16);
        // entry sent at all-ones is 1001 ms old at 1000: wrapped elapsed time
        add_row(ptt_pkg::CMD_EXPIRE, '0, '0, 1'b0, 32'd1000, '0, 1, 1'b0, 1'b0,
                ptt_pkg::STATUS_OK, '0, '0);
        add_row(ptt_pkg::CMD_EXPIRE, '0, '0, 1'b0, 32'hFFFF_FFFF, '0, 1, 1'b0, 1'b0,
                ptt_pkg::STATUS_OK, '0, '0);
        add_row(ptt_pkg::CMD_QUERY, '0, '0, 1'b0, '0, 32'd2, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_OK, '0, 5'd16);
        add_row(ptt_pkg::CMD_COMPLETE, '0, '0, 1'b0, '0, 32'd2, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_OK, '0, 5'd15);
        add_row(ptt_pkg::CMD_QUERY, '0, '0, 1'b0, '0, 32'd2, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_NOT_FOUND, '0, 5'd15);
        add_row(ptt_pkg::CMD_COMPLETE, '0, '0, 1'b0, '0, 32'd1, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_OK, '0, 5'd14);
        add_row(ptt_pkg::CMD_COMPLETE, '0, '0, 1'b0, '0, 32'd16, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_OK, '0, 5'd13);
        add_row(CMD_SPARE5, '0, '0, 1'b0, '0, '0, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_NOT_FOUND, '0, 5'd13);
        add_row(CMD_SPARE6, '0, '0, 1'b0, '0, '0, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_NOT_FOUND, '0, 5'd13);
        add_row(CMD_SPARE7, '0, '0, 1'b0, '0, '0, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_NOT_FOUND, '0, 5'd13);
        add_row(ptt_pkg::CMD_CLEAR, '0, '0, 1'b0, '0, '0, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_OK, '0, 5'd0);
        // the rejected begin on a full table must not have used up an id
        add_row(ptt_pkg::CMD_BEGIN, '0, '0, 1'b0, '0, '0, 1, 1'b0, 1'b1,
                ptt_pkg::STATUS_OK, 32'd17, 5'd1);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            for (k = 0; k < row.reps; k++)
            begin
                beat = row.beat;
                if (row.rnd)
                begin
                    beat.node_address = rand48();
                    beat.relay_pin = 8'($urandom_range(0, 255));
                    beat.desired_on = 1'($urandom_range(0, 1));
                    beat.now_ms = $urandom_range(0, 2000);
                    beat.command_id = $urandom;
                end
                issue(beat, row.typed, row.want);
            end
        end

        tmo_list = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd250, 32'd0, ptt_pkg::TIMEOUT_RESET};
        tmo_list[4] = $urandom_range(0, 3000);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain();
            set_timeout(tmo_list[phase]);
            // odd phases start just short of the millisecond wrap
            wall_ms = phase[0] ? 32'hFFFF_FC00 : $urandom;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 16 == 0)
                    idle_on = (phase != PHASES - 1) && ($urandom_range(0, 1) == 1);
                if (idle_on && $urandom_range(0, 2) == 0)
                    pause($urandom_range(1, 11));

                beat.node_address = rand48();
                beat.relay_pin = 8'($urandom_range(0, 255));
                beat.desired_on = 1'($urandom_range(0, 1));
                beat.now_ms = ($urandom_range(0, 19) == 0) ? $urandom : wall_ms;
                beat.command_id = $urandom;
                roll = $urandom_range(0, 99);
                if (roll < 40)
                begin
                    beat.command = ptt_pkg::CMD_BEGIN;
                end
                else if (roll < 62)
                begin
                    beat.command = ptt_pkg::CMD_COMPLETE;
                    beat.command_id = pick_id();
                end
                else if (roll < 77)
                begin
                    beat.command = ptt_pkg::CMD_QUERY;
                    beat.command_id = pick_id();
                end
                else if (roll < 93)
                begin
                    beat.command = ptt_pkg::CMD_EXPIRE;
                end
                else if (roll < 96)
                begin
                    beat.command = ptt_pkg::CMD_CLEAR;
                end
                else
                begin
                    beat.command = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
                end
                issue(beat, 1'b0, '0);
                wall_ms = wall_ms + $urandom_range(0, 200);
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
rtl/ptt_pkg.sv
rtl/ptt_mem.sv
rtl/ptt_cmp.sv
rtl/pending_command_timeout_tracker.sv
test/tb_pending_command_timeout_tracker.sv
